@@ rtl/cpd_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the frame receiver.
package cpd_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 2;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_BODY  = 2'd2,
      PH_CHECK = 2'd3
   } phase_type;

   localparam kind_type KIND_BODY = 2'd0;
   localparam kind_type KIND_GOOD = 2'd1;
   localparam kind_type KIND_BAD  = 2'd2;

   localparam csr_idx_type CSR_START_MARKER = 2'd0;
   localparam csr_idx_type CSR_MAX_LENGTH   = 2'd1;

   localparam byte_type START_MARKER_RST = 8'd170;
   localparam byte_type MAX_LENGTH_RST   = 8'd130;

   localparam byte_type CRC_POLY = 8'h07;
   localparam byte_type CRC_INIT = 8'h00;

   // CRC-8/SMBUS, MSB first, one byte per call
   function automatic byte_type crc8_update(byte_type crc, byte_type data);
      byte_type c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/cpd_if.sv @@
// Handshake channel interfaces: request, response and register write.
interface cpd_req_if;
   logic               valid;
   logic               ready;
   cpd_pkg::byte_type  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpd_rsp_if;
   logic               valid;
   logic               ready;
   cpd_pkg::kind_type  kind;
   cpd_pkg::byte_type  body_byte;
   cpd_pkg::byte_type  byte_index;
   cpd_pkg::byte_type  frame_length;

   modport source (output valid, output kind, output body_byte, output byte_index,
                   output frame_length, input ready);
   modport sink   (input valid, input kind, input body_byte, input byte_index,
                   input frame_length, output ready);
endinterface

interface cpd_csr_if;
   logic                 valid;
   logic                 ready;
   cpd_pkg::csr_idx_type index;
   cpd_pkg::byte_type    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/crc8_packet_deframer_unit.sv @@
// Length-prefixed frame receiver with running CRC-8/SMBUS check.
// A result is registered on rsp in the cycle after the request that causes it.
// Throughput: one request per cycle unless rsp stalls; the single-byte CRC
//   update and phase logic sit between the req handshake and the rsp register.
// req ready stays high while the response register is empty or being taken.
// Reset (synchronous): idle phase, count and CRC cleared, no response pending,
//   start_marker = 170, max_length = 130.
module crc8_packet_deframer_unit (
   input  logic          clock,
   input  logic          reset,
   cpd_req_if.sink       req_bus,
   cpd_rsp_if.source     rsp_bus,
   cpd_csr_if.sink       csr_bus
);
   import cpd_pkg::*;

   // configuration registers
   byte_type  start_marker_ff;
   byte_type  max_length_ff;

   // frame state
   phase_type phase_ff, phase_in;
   byte_type  exp_len_ff, exp_len_in;
   byte_type  rcv_cnt_ff, rcv_cnt_in;
   byte_type  crc_ff, crc_in;

   // response register
   logic      rsp_valid_ff;
   kind_type  rsp_kind_ff, rsp_kind_in;
   byte_type  rsp_byte_ff, rsp_byte_in;
   byte_type  rsp_idx_ff, rsp_idx_in;
   byte_type  rsp_len_ff, rsp_len_in;
   logic      rsp_load;

   logic      req_accept;
   byte_type  rx;
   byte_type  cnt_next;

   // accept whenever the output slot frees up this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rx            = req_bus.rx_byte;
   assign cnt_next      = rcv_cnt_ff + 8'd1;

   assign csr_bus.ready = 1'b1;

   // register writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         max_length_ff   <= MAX_LENGTH_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_START_MARKER: start_marker_ff <= csr_bus.data;
            CSR_MAX_LENGTH:   max_length_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:  if (rx == start_marker_ff) phase_in = PH_LEN;
         PH_LEN: begin
            // zero or oversize length drops the frame silently
            if (rx == '0 || rx > max_length_ff) phase_in = PH_IDLE;
            else                                phase_in = PH_BODY;
         end
         PH_BODY:  if (cnt_next >= exp_len_ff) phase_in = PH_CHECK;
         PH_CHECK: phase_in = PH_IDLE;
         default:  phase_in = PH_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      exp_len_in  = exp_len_ff;
      rcv_cnt_in  = rcv_cnt_ff;
      crc_in      = crc_ff;
      rsp_load    = 1'b0;
      rsp_kind_in = KIND_BODY;
      rsp_byte_in = rx;
      rsp_idx_in  = '0;
      rsp_len_in  = exp_len_ff;
      unique case (phase_ff)
         PH_IDLE: ;
         PH_LEN: begin
            // length is stored even when rejected
            exp_len_in = rx;
            rcv_cnt_in = '0;
            crc_in     = CRC_INIT;
         end
         PH_BODY: begin
            rsp_load    = 1'b1;
            rsp_kind_in = KIND_BODY;
            rsp_idx_in  = rcv_cnt_ff;
            crc_in      = crc8_update(crc_ff, rx);
            rcv_cnt_in  = cnt_next;
         end
         PH_CHECK: begin
            rsp_load    = 1'b1;
            rsp_kind_in = (rx == crc_ff) ? KIND_GOOD : KIND_BAD;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         exp_len_ff <= '0;
         rcv_cnt_ff <= '0;
         crc_ff     <= CRC_INIT;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         rcv_cnt_ff <= rcv_cnt_in;
         crc_ff     <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept && rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_idx_ff  <= rsp_idx_in;
         rsp_len_ff  <= rsp_len_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_kind_ff;
   assign rsp_bus.body_byte    = rsp_byte_ff;
   assign rsp_bus.byte_index   = rsp_idx_ff;
   assign rsp_bus.frame_length = rsp_len_ff;

   // body position always lies inside the announced length
   a_body_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_BODY |-> rsp_idx_ff < rsp_len_ff)
      else $error("body index beyond frame length");

   // end-of-frame responses carry index zero
   a_end_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_BODY |-> rsp_idx_ff == '0)
      else $error("end response with nonzero index");

   // while in the body, the count has not reached the length
   a_body_cnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> rcv_cnt_ff < exp_len_ff)
      else $error("body phase with count at length");

   // a rejected length returns to idle without a response
   a_len_drop: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == PH_LEN && (rx == '0 || rx > max_length_ff)
      |=> phase_ff == PH_IDLE && $stable(rsp_len_ff))
      else $error("rejected length did not drop frame");

endmodule
